### hw/rtl/multi_waveform_table_sample_assert.svh
// Assertion macros shared by the waveform sample block.
`ifndef MULTI_WAVEFORM_TABLE_SAMPLE_ASSERT_SVH
`define MULTI_WAVEFORM_TABLE_SAMPLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MWTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MWTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mwts_pkg.sv
// Types and constants of the waveform sample block.
`default_nettype none

package mwts_pkg;

  // Waveform selection.
  typedef enum logic [1:0] {
    MODE_TRI    = 2'd0,
    MODE_SQUARE = 2'd1,
    MODE_SAW    = 2'd2,
    MODE_SINE   = 2'd3
  } mwts_mode_e;

  // One request and one response.
  typedef struct packed {
    logic [1:0]  mode;
    logic [17:0] position;
  } mwts_req_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               out_of_range;
  } mwts_rsp_t;

  // Control that rides along the pipeline with every request.
  typedef struct packed {
    mwts_mode_e mode;
    logic       oor;
    logic       sq_hi;
  } mwts_side_t;

  localparam logic [17:0] LEN_RESET = 18'd44100;
  localparam int QUOT_BITS = 33;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [15:0] Q15_MAX     = 16'h7FFF;
  localparam logic [15:0] Q15_MIN     = 16'h8000;

  // Reciprocal multipliers: floor(n/d) = (n*M) >> S for any 32-bit n.
  localparam int SH_40 = 38;
  localparam int SH_72 = 39;
  localparam int SH_42 = 38;
  localparam int SH_20 = 37;
  localparam int SH_6  = 35;
  localparam logic [32:0] MAG_40 = 33'(((64'd1 << SH_40) / 64'd40) + 64'd1);
  localparam logic [32:0] MAG_72 = 33'(((64'd1 << SH_72) / 64'd72) + 64'd1);
  localparam logic [32:0] MAG_42 = 33'(((64'd1 << SH_42) / 64'd42) + 64'd1);
  localparam logic [32:0] MAG_20 = 33'(((64'd1 << SH_20) / 64'd20) + 64'd1);
  localparam logic [32:0] MAG_6  = 33'(((64'd1 << SH_6) / 64'd6) + 64'd1);

endpackage

`default_nettype wire

### hw/rtl/mwts_front.sv
// Front end: per-waveform operand selection and dividend/divisor forming.
`default_nettype none

module mwts_front import mwts_pkg::*; #(
  parameter int P = 18
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire mwts_req_t          req_i,
  input  wire logic [P-1:0]       len_i,
  input  wire logic [P-1:0]       half_i,
  input  wire logic [P-1:0]       fl_i,
  input  wire logic [P-1:0]       b_i,
  input  wire logic [2*P-1:0]     lsq_i,
  output logic                    valid_o,
  output mwts_side_t              side_o,
  output logic [2*P+32:0]         num_o,
  output logic [2*P-1:0]          den_o
);

  localparam int CW = 2*P+33;
  localparam int DW = 2*P;

  logic [P-1:0]   pos;
  logic [P:0]     twice_h;
  logic [P-1:0]   k_a;
  logic [P-1:0]   diff;
  logic [P+5:0]   d40;
  logic [P-1:0]   rest;
  logic           fall_a;
  logic [P-1:0]   opnd_a;
  mwts_side_t     side_a;

  logic           va_q;
  mwts_side_t     side_a_q;
  logic [P-1:0]   opnd_q;
  logic           fall_q;

  logic [DW-1:0]  prod;
  logic [CW-1:0]  num_d;
  logic [DW-1:0]  den_d;
  logic           vb_q;
  mwts_side_t     side_b_q;
  logic [CW-1:0]  num_q;
  logic [DW-1:0]  den_q;

  // Stage A: triangle fold, saw fall distance, operand choice.
  always_comb begin
    pos     = P'(req_i.position);
    twice_h = {half_i, 1'b0};
    if (pos < half_i) begin
      k_a = pos;
    end else if (twice_h >= (P+1)'(pos)) begin
      k_a = P'(twice_h - (P+1)'(pos));
    end else begin
      k_a = '0;
    end
    fall_a = pos >= fl_i;
    diff   = pos - fl_i;
    d40    = ((P+6)'(diff) << 5) + ((P+6)'(diff) << 3);
    rest   = ((P+6)'(len_i) >= d40) ? P'((P+6)'(len_i) - d40) : '0;
    side_a.mode  = mwts_mode_e'(req_i.mode);
    side_a.oor   = pos >= len_i;
    side_a.sq_hi = pos >= half_i;
    case (side_a.mode)
      MODE_TRI:  opnd_a = k_a;
      MODE_SAW:  opnd_a = fall_a ? rest : pos;
      MODE_SINE: opnd_a = pos;
      default:   opnd_a = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_a_q <= side_a;
      opnd_q   <= opnd_a;
      fall_q   <= fall_a;
    end
  end

  // Stage B: scale the operand into the dividend and pick the divisor.
  always_comb begin
    prod  = DW'(b_i) * DW'(opnd_q);
    den_d = DW'(len_i);
    case (side_a_q.mode)
      MODE_TRI:  num_d = CW'(opnd_q) << 17;
      MODE_SAW: begin
        if (fall_q) begin
          num_d = CW'(prod) << 16;
          den_d = lsq_i;
        end else begin
          num_d = CW'(opnd_q) << 16;
        end
      end
      MODE_SINE: num_d = CW'(opnd_q) << 32;
      default:   num_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_b_q <= side_a_q;
      num_q    <= num_d;
      den_q    <= den_d;
    end
  end

  assign valid_o = vb_q;
  assign side_o  = side_b_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

`default_nettype wire

### hw/rtl/mwts_div.sv
// Pipelined restoring divider, one quotient bit per stage, then rounding.
`default_nettype none

module mwts_div import mwts_pkg::*; #(
  parameter int P = 18
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire mwts_side_t         side_i,
  input  wire logic [2*P+32:0]    num_i,
  input  wire logic [2*P-1:0]     den_i,
  output logic                    valid_o,
  output mwts_side_t              side_o,
  output logic [QUOT_BITS:0]      quot_o
);

  localparam int CW   = 2*P+33;
  localparam int DW   = 2*P;
  localparam int LAST = QUOT_BITS-1;

  logic [CW-1:0]        rem_q  [QUOT_BITS];
  logic [DW-1:0]        den_q  [QUOT_BITS];
  logic [QUOT_BITS-1:0] quot_q [QUOT_BITS];
  mwts_side_t           side_q [QUOT_BITS];
  logic [QUOT_BITS-1:0] vld_q;

  logic [CW-1:0]        rem_in  [QUOT_BITS];
  logic [DW-1:0]        den_in  [QUOT_BITS];
  logic [QUOT_BITS-1:0] quot_in [QUOT_BITS];
  mwts_side_t           side_in [QUOT_BITS];
  logic [CW-1:0]        rem_d   [QUOT_BITS];
  logic [QUOT_BITS-1:0] quot_d  [QUOT_BITS];

  logic [CW:0]          rem2;
  logic                 up;
  logic [QUOT_BITS:0]   quot_r_d;
  logic                 vr_q;
  mwts_side_t           side_r_q;
  logic [QUOT_BITS:0]   quot_r_q;

  // Each stage tries the divisor shifted to its own quotient bit.
  always_comb begin
    logic [CW-1:0] sh;
    rem_in[0]  = num_i;
    den_in[0]  = den_i;
    quot_in[0] = '0;
    side_in[0] = side_i;
    for (int s = 1; s < QUOT_BITS; s++) begin
      rem_in[s]  = rem_q[s-1];
      den_in[s]  = den_q[s-1];
      quot_in[s] = quot_q[s-1];
      side_in[s] = side_q[s-1];
    end
    for (int s = 0; s < QUOT_BITS; s++) begin
      sh = CW'(den_in[s]) << (QUOT_BITS-1-s);
      if (rem_in[s] >= sh) begin
        rem_d[s]  = rem_in[s] - sh;
        quot_d[s] = quot_in[s] | (QUOT_BITS'(1) << (QUOT_BITS-1-s));
      end else begin
        rem_d[s]  = rem_in[s];
        quot_d[s] = quot_in[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QUOT_BITS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QUOT_BITS; s++) begin
        rem_q[s]  <= rem_d[s];
        den_q[s]  <= den_in[s];
        quot_q[s] <= quot_d[s];
        side_q[s] <= side_in[s];
      end
    end
  end

  // Round to nearest, halves up, from the final remainder.
  always_comb begin
    rem2     = {rem_q[LAST], 1'b0};
    up       = rem2 >= (CW+1)'(den_q[LAST]);
    quot_r_d = (QUOT_BITS+1)'(quot_q[LAST]) + (QUOT_BITS+1)'(up);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (en_i) begin
      vr_q <= vld_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_r_q <= side_q[LAST];
      quot_r_q <= quot_r_d;
    end
  end

  assign valid_o = vr_q;
  assign side_o  = side_r_q;
  assign quot_o  = quot_r_q;

endmodule

`default_nettype wire

### hw/rtl/mwts_sine.sv
// Sine polynomial pipeline and final Q1.15 result selection.
`default_nettype none

module mwts_sine import mwts_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire mwts_side_t         side_i,
  input  wire logic [QUOT_BITS:0] quot_i,
  output logic                    valid_o,
  output mwts_rsp_t               rsp_o
);

  localparam int NS = 12;

  typedef struct packed {
    mwts_side_t  side;
    logic [1:0]  quad;
    logic [15:0] lin;
  } mwts_tag_t;

  logic [NS-1:0] vld_q;
  mwts_tag_t     tag_q [NS-1];
  mwts_tag_t     tag0;
  logic [31:0]   u;
  logic [30:0]   f0;
  logic [30:0]   f_q;
  logic [30:0]   x_q  [9];
  logic [31:0]   x2_q [6];
  logic [31:0]   a72_q, a42_q, a20_q, a6_q;
  logic [31:0]   pr1_q, pr2_q, pr3_q;
  logic [30:0]   s_q;

  logic [16:0]   m17;
  logic [15:0]   mag;
  logic [15:0]   sval;
  mwts_rsp_t     rsp_d;
  mwts_rsp_t     rsp_q;

  // Phase fold into the first quarter; linear waveforms get clamped here.
  always_comb begin
    u         = quot_i[31:0];
    tag0.side = side_i;
    tag0.quad = u[31:30];
    f0        = u[30] ? (Q30_ONE - {1'b0, u[29:0]}) : {1'b0, u[29:0]};
    tag0.lin  = (quot_i >= (QUOT_BITS+1)'(65535)) ? Q15_MAX : (quot_i[15:0] ^ Q15_MIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  // Horner steps of the Taylor series, one multiply per stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag0;
      for (int k = 1; k < NS-1; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
      f_q     <= f0;
      x_q[0]  <= 31'((62'(f_q) * 62'(HALF_PI_Q30)) >> 30);
      for (int k = 1; k < 9; k++) begin
        x_q[k] <= x_q[k-1];
      end
      x2_q[0] <= 32'((62'(x_q[0]) * 62'(x_q[0])) >> 30);
      for (int k = 1; k < 6; k++) begin
        x2_q[k] <= x2_q[k-1];
      end
      a72_q <= 32'((66'(x2_q[0]) * 66'(MAG_72)) >> SH_72);
      pr1_q <= 32'((63'(x2_q[1]) * 63'(Q30_ONE - 31'(a72_q))) >> 30);
      a42_q <= 32'((66'(pr1_q) * 66'(MAG_42)) >> SH_42);
      pr2_q <= 32'((63'(x2_q[3]) * 63'(Q30_ONE - 31'(a42_q))) >> 30);
      a20_q <= 32'((66'(pr2_q) * 66'(MAG_20)) >> SH_20);
      pr3_q <= 32'((63'(x2_q[5]) * 63'(Q30_ONE - 31'(a20_q))) >> 30);
      a6_q  <= 32'((66'(pr3_q) * 66'(MAG_6)) >> SH_6);
      s_q   <= 31'((62'(x_q[8]) * 62'(Q30_ONE - 31'(a6_q))) >> 30);
      rsp_q <= rsp_d;
    end
  end

  // Final rounding, sign, waveform selection and zeroing of out-of-range samples.
  always_comb begin
    m17  = 17'((32'(s_q) + 32'd16384) >> 15);
    mag  = (m17 > 17'(Q15_MAX)) ? Q15_MAX : m17[15:0];
    sval = tag_q[NS-2].quad[1] ? (16'd0 - mag) : mag;
    rsp_d.out_of_range = tag_q[NS-2].side.oor;
    case (tag_q[NS-2].side.mode)
      MODE_TRI:    rsp_d.sample = tag_q[NS-2].lin;
      MODE_SQUARE: rsp_d.sample = tag_q[NS-2].side.sq_hi ? Q15_MAX : Q15_MIN;
      MODE_SAW:    rsp_d.sample = tag_q[NS-2].lin;
      MODE_SINE:   rsp_d.sample = sval;
      default:     rsp_d.sample = '0;
    endcase
    if (tag_q[NS-2].side.oor) begin
      rsp_d.sample = '0;
    end
  end

  assign valid_o = vld_q[NS-1];
  assign rsp_o   = rsp_q;

endmodule

`default_nettype wire

### hw/rtl/multi_waveform_table_sample.sv
// A request passes through the front end, the divider and the sine pipeline in turn.
// Throughput: one request per cycle unless the output stalls or the length terms
// settle, set by the divider pipeline (33 quotient stages, then rounding) and
// the 12-stage sine polynomial pipeline, all advancing together.
// Reset clears all valid bits; the length register returns to 44100.
// After reset and after each length write the input stalls while the settle
// counter runs down and the derived length terms settle.
`default_nettype none

`include "multi_waveform_table_sample_assert.svh"

module multi_waveform_table_sample import mwts_pkg::*; #(
  parameter int POSITION_BITS = 18
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [17:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire mwts_req_t   in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output mwts_rsp_t        out_rsp_o
);

  localparam int P  = POSITION_BITS;
  localparam int CW = 2*P+33;
  localparam int DW = 2*P;
  localparam logic [1:0] CFG_SETTLE = 2'd3;

  logic [17:0]    table_length_q;
  logic [1:0]     cfg_cnt_q;
  logic           busy;
  logic [P-1:0]   len;
  logic [P+5:0]   t39_q;
  logic [DW-1:0]  lsq_q;
  logic [P-1:0]   half_q;
  logic [P-1:0]   fl_q;
  logic [P-1:0]   b_q;
  logic [63:0]    fl_prod;

  logic           en;
  logic           in_acc;
  logic           fv;
  mwts_side_t     fside;
  logic [CW-1:0]  fnum;
  logic [DW-1:0]  fden;
  logic           dv;
  mwts_side_t     dside;
  logic [QUOT_BITS:0] dquot;

  // Length register and settle counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= LEN_RESET;
      cfg_cnt_q      <= CFG_SETTLE;
    end else if (cfg_we_i) begin
      table_length_q <= cfg_wdata_i;
      cfg_cnt_q      <= CFG_SETTLE;
    end else if (busy) begin
      cfg_cnt_q      <= cfg_cnt_q - 2'd1;
    end
  end

  assign busy    = cfg_cnt_q != 2'd0;
  assign len     = P'(table_length_q);
  assign fl_prod = 64'(t39_q) * 64'(MAG_40);

  // Derived length terms: half, square, floor and ceiling of 39L/40.
  always_ff @(posedge clk_i) begin
    t39_q  <= (P+6)'(len) * 6'd39;
    lsq_q  <= DW'(len) * DW'(len);
    half_q <= len >> 1;
    fl_q   <= P'(fl_prod >> SH_40);
    b_q    <= fl_q + P'(((P+6)'(fl_q) * 6'd40) != t39_q);
  end

  // The whole pipeline advances whenever the output register can move.
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en || busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  mwts_front #(.P(P)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_acc),
    .req_i   (in_req_i),
    .len_i   (len),
    .half_i  (half_q),
    .fl_i    (fl_q),
    .b_i     (b_q),
    .lsq_i   (lsq_q),
    .valid_o (fv),
    .side_o  (fside),
    .num_o   (fnum),
    .den_o   (fden)
  );

  mwts_div #(.P(P)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .side_i  (fside),
    .num_i   (fnum),
    .den_i   (fden),
    .valid_o (dv),
    .side_o  (dside),
    .quot_o  (dquot)
  );

  mwts_sine u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv),
    .side_i  (dside),
    .quot_i  (dquot),
    .valid_o (out_valid_o),
    .rsp_o   (out_rsp_o)
  );

  // A length write must hold off requests while the derived terms settle.
  `MWTS_ASSERT_NXT(a_cfg_stall, cfg_we_i, in_stall_o, "request taken right after length write")
  // A stalled response freezes the pipeline, so no request may enter.
  `MWTS_ASSERT_IMP(a_freeze, out_valid_o && out_stall_i, in_stall_o, "request taken while frozen")
  // Out-of-range responses carry a zero sample.
  `MWTS_ASSERT_IMP(a_oor_zero, out_valid_o && out_rsp_o.out_of_range,
                   out_rsp_o.sample == 16'sd0, "out-of-range response with nonzero sample")

endmodule

`default_nettype wire
